@@ src/cle_pkg.sv @@
`timescale 1ns / 1ps

package cle_pkg;

  // Ring geometry; the depth must be a power of two.
  localparam int unsigned RING_DEPTH = 128;
  localparam int unsigned SLOT_W     = $clog2(RING_DEPTH);
  // Indices carry one extra wrap bit so that full and empty differ.
  localparam int unsigned IDX_W      = SLOT_W + 1;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CNT_W      = 8;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Character codes with a special meaning.
  localparam char_t CH_NUL  = 8'h00;
  localparam char_t CH_EOF  = 8'h04;
  localparam char_t CH_BS   = 8'h08;
  localparam char_t CH_LF   = 8'h0A;
  localparam char_t CH_CR   = 8'h0D;
  localparam char_t CH_DUMP = 8'h10;
  localparam char_t CH_KILL = 8'h15;
  localparam char_t CH_ESC  = 8'h1B;
  localparam char_t CH_DEL  = 8'h7F;

  // Item modes on the input side.
  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [2:0] {
    KIND_ECHO  = 3'd0,
    KIND_ERASE = 3'd1,
    KIND_READ  = 3'd2,
    KIND_EMPTY = 3'd3,
    KIND_EOF   = 3'd4
  } kind_e;

  // One result item.
  typedef struct packed {
    kind_e kind;
    char_t data;
    cnt_t  erase_count;
    logic  line_ready;
    logic  end_of_line;
  } result_t;

  // Write request from the editing logic to the ring.
  typedef struct packed {
    logic  en;
    slot_t addr;
    char_t data;
  } ring_wr_t;

endpackage

@@ src/cle_ring.sv @@
`timescale 1ns / 1ps

module cle_ring (
  input  logic              clk_i,
  input  cle_pkg::ring_wr_t wr_i,
  input  cle_pkg::slot_t    rd_addr_i,
  output cle_pkg::char_t    head_o
);

  cle_pkg::char_t mem_q [cle_pkg::RING_DEPTH];
  cle_pkg::char_t head_q;

  // Line storage, one write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read of the byte at the next read slot; a write to that same
  // slot in this cycle is passed straight through.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
      head_q <= wr_i.data;
    end else begin
      head_q <= mem_q[rd_addr_i];
    end
  end

  assign head_o = head_q;

endmodule

@@ src/cle_core.sv @@
`timescale 1ns / 1ps

module cle_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              mode_i,
  input  cle_pkg::char_t    char_i,
  input  logic              first_i,
  input  cle_pkg::char_t    head_i,
  output cle_pkg::ring_wr_t wr_o,
  output cle_pkg::slot_t    rd_addr_o,
  output logic              res_valid_o,
  output cle_pkg::result_t  res_o
);

  cle_pkg::idx_t read_q, read_d;
  cle_pkg::idx_t commit_q, commit_d;
  cle_pkg::idx_t edit_q, edit_d;

  cle_pkg::idx_t  pending;
  cle_pkg::idx_t  used;
  cle_pkg::char_t typed;
  logic           full;

  assign pending = edit_q - commit_q;
  assign used    = edit_q - read_q;
  assign full    = used[cle_pkg::IDX_W-1];
  assign typed   = (char_i == cle_pkg::CH_CR) ? cle_pkg::CH_LF : char_i;

  // Decide the result and the index updates for the item in hand.
  always_comb begin
    read_d      = read_q;
    commit_d    = commit_q;
    edit_d      = edit_q;
    wr_o        = '0;
    res_valid_o = 1'b0;
    res_o       = '{kind: cle_pkg::KIND_EMPTY, data: '0, erase_count: '0,
                    line_ready: 1'b0, end_of_line: 1'b0};

    if (fire_i) begin
      if (mode_i == cle_pkg::MODE_READ) begin
        res_valid_o = 1'b1;
        priority if (read_q == commit_q) begin
          res_o.kind = cle_pkg::KIND_EMPTY;
        end else if (head_i == cle_pkg::CH_EOF) begin
          // End of file is consumed only at the start of a read call.
          if (first_i) begin
            read_d = read_q + cle_pkg::idx_t'(1);
          end
          res_o.kind = cle_pkg::KIND_EOF;
          res_o.data = cle_pkg::CH_EOF;
        end else begin
          read_d            = read_q + cle_pkg::idx_t'(1);
          res_o.kind        = cle_pkg::KIND_READ;
          res_o.data        = head_i;
          res_o.end_of_line = (head_i == cle_pkg::CH_LF);
        end
      end else begin
        priority if ((char_i == cle_pkg::CH_ESC) || (char_i == cle_pkg::CH_DUMP) ||
                     (char_i == cle_pkg::CH_NUL)) begin
          // Discarded silently.
        end else if (char_i == cle_pkg::CH_KILL) begin
          if (pending != '0) begin
            edit_d            = commit_q;
            res_valid_o       = 1'b1;
            res_o.kind        = cle_pkg::KIND_ERASE;
            res_o.erase_count = cle_pkg::cnt_t'(pending);
          end
        end else if ((char_i == cle_pkg::CH_BS) || (char_i == cle_pkg::CH_DEL)) begin
          if (pending != '0) begin
            edit_d            = edit_q - cle_pkg::idx_t'(1);
            res_valid_o       = 1'b1;
            res_o.kind        = cle_pkg::KIND_ERASE;
            res_o.erase_count = cle_pkg::cnt_t'(1);
          end
        end else if (!full) begin
          // Store and echo; a newline, end of file or a ring that has just
          // filled up commits the line.
          wr_o.en     = 1'b1;
          wr_o.addr   = edit_q[cle_pkg::SLOT_W-1:0];
          wr_o.data   = typed;
          edit_d      = edit_q + cle_pkg::idx_t'(1);
          res_valid_o = 1'b1;
          res_o.kind  = cle_pkg::KIND_ECHO;
          res_o.data  = typed;
          if ((typed == cle_pkg::CH_LF) || (typed == cle_pkg::CH_EOF) ||
              (used == cle_pkg::idx_t'(cle_pkg::RING_DEPTH - 1))) begin
            commit_d         = edit_q + cle_pkg::idx_t'(1);
            res_o.line_ready = 1'b1;
          end
        end
      end
    end
  end

  // The ring keeps the byte at the next read slot ready.
  assign rd_addr_o = read_d[cle_pkg::SLOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_q   <= '0;
      commit_q <= '0;
      edit_q   <= '0;
    end else begin
      read_q   <= read_d;
      commit_q <= commit_d;
      edit_q   <= edit_d;
    end
  end

endmodule

@@ src/console_line_editor_top.sv @@
`timescale 1ns / 1ps

// Console line editor: a terminal line discipline over a 128-byte ring. Each
// input item is either a received character (tuser bit 0 low) or a request
// for one committed byte (tuser bit 0 high, tuser bit 1 marking the first
// byte of a read call). The block takes one item every clock cycle unless the
// result register is stalled; its result, if any, passes through the input
// register and then the result register. The rate is set by the update of the
// read, commit and edit indices as each item is processed and by the ring's
// read port, which always holds the byte at the next read position ready, so
// reads may follow reads and writes back to back. Ring bytes are undefined
// after reset and there is no clearing pass; only bytes that were typed are
// ever read out. Discarded characters (ESC, ^P, NUL, erasing with nothing
// pending, typing into a full ring) give no result item.

module console_line_editor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_in
  input  logic [1:0]  s_axis_tuser,   // mode, first_of_read
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // data, erase_count
  output logic [3:0]  m_axis_tuser,   // kind (3 bits), line_ready
  output logic        m_axis_tlast    // end_of_line
);

  logic              in_valid_q;
  logic              in_mode_q;
  cle_pkg::char_t    in_char_q;
  logic              in_first_q;
  logic              fire;
  logic              out_valid_q;
  cle_pkg::result_t  out_q;
  cle_pkg::ring_wr_t ring_wr;
  cle_pkg::slot_t    rd_addr;
  cle_pkg::char_t    head;
  logic              res_valid;
  cle_pkg::result_t  res;

  // The item in the input register is processed when the result register
  // is free or being emptied.
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode_q  <= s_axis_tuser[0];
      in_char_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser[1];
    end
  end

  cle_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .mode_i      (in_mode_q),
    .char_i      (in_char_q),
    .first_i     (in_first_q),
    .head_i      (head),
    .wr_o        (ring_wr),
    .rd_addr_o   (rd_addr),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cle_ring u_ring (
    .clk_i     (clk_i),
    .wr_i      (ring_wr),
    .rd_addr_i (rd_addr),
    .head_o    (head)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.erase_count, out_q.data};
  assign m_axis_tuser  = {out_q.line_ready, out_q.kind};
  assign m_axis_tlast  = out_q.end_of_line;

endmodule

@@ src/cle_checker.sv @@
`timescale 1ns / 1ps

module cle_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic [2:0] kind;
  assign kind = m_axis_tuser[2:0];

  // A stalled result item holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result item changed while stalled");

  // Only the defined kinds are ever produced.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (kind == cle_pkg::KIND_ECHO) || (kind == cle_pkg::KIND_ERASE) ||
      (kind == cle_pkg::KIND_READ) || (kind == cle_pkg::KIND_EMPTY) ||
      (kind == cle_pkg::KIND_EOF))
    else $error("undefined result kind");

  // A line is committed only by an echoed character.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[3] |-> kind == cle_pkg::KIND_ECHO)
    else $error("line ready on a non-echo item");

  // End of line marks only bytes handed to a reader, and then a newline.
  a_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      (kind == cle_pkg::KIND_READ) && (m_axis_tdata[7:0] == cle_pkg::CH_LF))
    else $error("end of line on a wrong item");

  // An erase always removes something and carries no character.
  a_erase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (kind == cle_pkg::KIND_ERASE) |->
      (m_axis_tdata[15:8] != 8'd0) && (m_axis_tdata[7:0] == 8'd0))
    else $error("malformed erase item");

endmodule

bind console_line_editor_top cle_checker u_cle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

@@ test/tb_console_line_editor_top.sv @@
`timescale 1ns / 1ps

module tb_console_line_editor_top;

  localparam int unsigned ITEM_TARGET = 1100;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;    // char_in
  logic [1:0]  s_axis_tuser  = '0;    // mode, first_of_read
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // data, erase_count
  logic [3:0]  m_axis_tuser;          // kind (3 bits), line_ready
  logic        m_axis_tlast;          // end_of_line

  console_line_editor_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Shadow copy of the line editor state.
  cle_pkg::char_t line_ring_sh [cle_pkg::RING_DEPTH];
  cle_pkg::idx_t  rd_idx = '0;
  cle_pkg::idx_t  cm_idx = '0;
  cle_pkg::idx_t  ed_idx = '0;

  cle_pkg::result_t tty_results_q [$];
  bit      idle_on       = 1'b1;
  int      items_in      = 0;
  int      discarded     = 0;
  int      mismatches    = 0;
  int      results_seen  = 0;
  int      max_erase     = 0;
  int      kind_seen [5] = '{default: 0};
  int      stall_cycles  = 0;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Number of bytes held between the read index and the edit index.
  function automatic int unsigned ring_fill();
    return {24'd0, cle_pkg::idx_t'(ed_idx - rd_idx)};
  endfunction

  // Applies one item to the shadow state and works out its result, if any.
  function automatic bit edit_line(input logic mode, input cle_pkg::char_t ch,
                                   input logic first, output cle_pkg::result_t res);
    cle_pkg::char_t c;
    cle_pkg::char_t b;
    cle_pkg::idx_t  n;
    res = '0;
    if (mode == cle_pkg::MODE_READ) begin
      if (rd_idx == cm_idx) begin
        res.kind = cle_pkg::KIND_EMPTY;
        return 1'b1;
      end
      b = line_ring_sh[cle_pkg::slot_t'(rd_idx)];
      // An end-of-file mark is only consumed at the start of a read call.
      if (b == cle_pkg::CH_EOF) begin
        if (first) rd_idx = rd_idx + cle_pkg::idx_t'(1);
        res.kind = cle_pkg::KIND_EOF;
        res.data = cle_pkg::CH_EOF;
        return 1'b1;
      end
      rd_idx = rd_idx + cle_pkg::idx_t'(1);
      res.kind        = cle_pkg::KIND_READ;
      res.data        = b;
      res.end_of_line = (b == cle_pkg::CH_LF);
      return 1'b1;
    end
    c = ch;
    if (c == cle_pkg::CH_ESC || c == cle_pkg::CH_DUMP || c == cle_pkg::CH_NUL) return 1'b0;
    if (c == cle_pkg::CH_KILL) begin
      n = cle_pkg::idx_t'(ed_idx - cm_idx);
      if (n == '0) return 1'b0;
      ed_idx           = cm_idx;
      res.kind         = cle_pkg::KIND_ERASE;
      res.erase_count  = cle_pkg::cnt_t'(n);
      return 1'b1;
    end
    if (c == cle_pkg::CH_BS || c == cle_pkg::CH_DEL) begin
      if (ed_idx == cm_idx) return 1'b0;
      ed_idx          = ed_idx - cle_pkg::idx_t'(1);
      res.kind        = cle_pkg::KIND_ERASE;
      res.erase_count = cle_pkg::cnt_t'(1);
      return 1'b1;
    end
    // Typing into a full ring is silently dropped.
    if (ring_fill() >= cle_pkg::RING_DEPTH) return 1'b0;
    if (c == cle_pkg::CH_CR) c = cle_pkg::CH_LF;
    line_ring_sh[cle_pkg::slot_t'(ed_idx)] = c;
    ed_idx   = ed_idx + cle_pkg::idx_t'(1);
    res.kind = cle_pkg::KIND_ECHO;
    res.data = c;
    if (c == cle_pkg::CH_LF || c == cle_pkg::CH_EOF || ring_fill() == cle_pkg::RING_DEPTH) begin
      cm_idx         = ed_idx;
      res.line_ready = 1'b1;
    end
    return 1'b1;
  endfunction

  // Presents one item, waits for it to be taken and records what it should cause.
  task automatic send_item(input logic mode, input cle_pkg::char_t ch, input logic first,
                           output bit has_res, output cle_pkg::result_t res);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 99) < 12) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= {first, mode};
    do @(posedge clk_i); while (!s_axis_tready);
    has_res = edit_line(mode, ch, first, res);
    items_in++;
    if (has_res) begin
      tty_results_q.push_back(res);
      kind_seen[int'(res.kind)]++;
      if (res.kind == cle_pkg::KIND_ERASE && int'(res.erase_count) > max_erase)
        max_erase = int'(res.erase_count);
    end else begin
      discarded++;
    end
  endtask

  task automatic type_char(input cle_pkg::char_t ch);
    bit               has_res;
    cle_pkg::result_t res;
    send_item(cle_pkg::MODE_CHAR, ch, logic'($urandom_range(0, 1)), has_res, res);
  endtask

  // One read call: bytes are requested until a newline, an end-of-file mark,
  // an empty ring or the call's length is reached.
  task automatic read_call(input int max_len, output cle_pkg::kind_e last_kind);
    bit               has_res;
    cle_pkg::result_t res;
    last_kind = cle_pkg::KIND_EMPTY;
    for (int k = 0; k < max_len; k++) begin
      send_item(cle_pkg::MODE_READ, cle_pkg::char_t'($urandom_range(0, 255)),
                logic'(k == 0), has_res, res);
      last_kind = res.kind;
      if (res.kind != cle_pkg::KIND_READ || res.end_of_line) break;
    end
  endtask

  // Reads until nothing committed is left, then clears any pending edit.
  task automatic drain_ring();
    cle_pkg::kind_e last_kind;
    do read_call(cle_pkg::RING_DEPTH * 2, last_kind); while (last_kind != cle_pkg::KIND_EMPTY);
    type_char(cle_pkg::CH_KILL);
  endtask

  // A byte as typed on a keyboard, with edits and the odd stray code.
  function automatic cle_pkg::char_t line_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62) return cle_pkg::char_t'($urandom_range(8'h20, 8'h7E));
    if (r < 68) return cle_pkg::CH_BS;
    if (r < 72) return cle_pkg::CH_DEL;
    if (r < 74) return cle_pkg::CH_KILL;
    if (r < 76) return cle_pkg::CH_ESC;
    if (r < 77) return cle_pkg::CH_DUMP;
    if (r < 78) return cle_pkg::CH_NUL;
    return cle_pkg::char_t'($urandom_range(0, 255));
  endfunction

  task automatic note_mismatch(input string why, input cle_pkg::result_t want,
                               input cle_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: kind %0d/%0d data %02h/%02h count %0d/%0d ready %b/%b eol %b/%b",
               $realtime, why, want.kind, got.kind, want.data, got.data,
               want.erase_count, got.erase_count, want.line_ready, got.line_ready,
               want.end_of_line, got.end_of_line);
  endtask

  // Result side: random back-pressure and field by field comparison.
  always @(posedge clk_i) begin
    m_axis_tready <= idle_on ? ($urandom_range(0, 99) >= 20) : 1'b1;
  end

  always @(posedge clk_i) begin
    cle_pkg::result_t got;
    cle_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind        = cle_pkg::kind_e'(m_axis_tuser[2:0]);
      got.data        = m_axis_tdata[7:0];
      got.erase_count = m_axis_tdata[15:8];
      got.line_ready  = m_axis_tuser[3];
      got.end_of_line = m_axis_tlast;
      results_seen++;
      if (tty_results_q.size() == 0) begin
        note_mismatch("unexpected result item", '0, got);
      end else begin
        want = tty_results_q.pop_front();
        if (got.kind !== want.kind || got.data !== want.data ||
            got.erase_count !== want.erase_count || got.line_ready !== want.line_ready ||
            got.end_of_line !== want.end_of_line)
          note_mismatch("result mismatch (expected/actual)", want, got);
      end
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Edge cases of the editor: discarded codes, erasing, commits and reads.
  task automatic test_directed_cases();
    cle_pkg::kind_e   last_kind;
    bit               has_res;
    cle_pkg::result_t res;
    idle_on = 1'b1;
    send_item(cle_pkg::MODE_READ, 8'hFF, 1'b1, has_res, res);
    type_char(cle_pkg::CH_BS);
    type_char(cle_pkg::CH_DEL);
    type_char(cle_pkg::CH_KILL);
    type_char(cle_pkg::CH_NUL);
    type_char(cle_pkg::CH_ESC);
    type_char(cle_pkg::CH_DUMP);
    type_char(8'h41);
    type_char(8'hFF);
    type_char(8'h01);
    type_char(cle_pkg::CH_BS);
    type_char(8'h80);
    type_char(cle_pkg::CH_KILL);
    type_char(8'h7E);
    type_char(cle_pkg::CH_CR);
    type_char(cle_pkg::CH_EOF);
    send_item(cle_pkg::MODE_READ, 8'h00, 1'b0, has_res, res);
    send_item(cle_pkg::MODE_READ, 8'hAA, 1'b0, has_res, res);
    send_item(cle_pkg::MODE_READ, 8'h55, 1'b0, has_res, res);
    send_item(cle_pkg::MODE_READ, 8'h00, 1'b1, has_res, res);
    read_call(1, last_kind);
  endtask

  // Fills the ring to the brim with no idling on either side.
  task automatic test_full_ring();
    cle_pkg::char_t c;
    idle_on = 1'b0;
    drain_ring();
    // The longest uncommitted line, then erased in one go.
    repeat (cle_pkg::RING_DEPTH - 1) begin
      do c = cle_pkg::char_t'($urandom_range(8'h20, 8'hFF)); while (c == cle_pkg::CH_DEL);
      type_char(c);
    end
    type_char(cle_pkg::CH_KILL);
    // The last byte that fits commits the line; the rest are dropped.
    repeat (cle_pkg::RING_DEPTH + 2) begin
      do c = cle_pkg::char_t'($urandom_range(8'h20, 8'hFF)); while (c == cle_pkg::CH_DEL);
      type_char(c);
    end
    type_char(cle_pkg::CH_BS);
    drain_ring();
  endtask

  // Lines of random content with edits, read calls and stray items.
  task automatic test_random_lines();
    int               r;
    cle_pkg::kind_e   last_kind;
    bit               has_res;
    cle_pkg::result_t res;
    idle_on = 1'b1;
    while (items_in < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        repeat ($urandom_range(0, 24)) type_char(line_char());
        r = $urandom_range(0, 9);
        if (r < 5)      type_char(cle_pkg::CH_LF);
        else if (r < 7) type_char(cle_pkg::CH_CR);
        else if (r < 8) type_char(cle_pkg::CH_EOF);
      end else if (r < 92) begin
        read_call($urandom_range(1, 40), last_kind);
      end else begin
        send_item(logic'($urandom_range(0, 1)), cle_pkg::char_t'($urandom_range(0, 255)),
                  logic'($urandom_range(0, 1)), has_res, res);
      end
    end
  endtask

  // Stops the input side, lets every result arrive and gives the verdict.
  task automatic finish_run();
    s_axis_tvalid <= 1'b0;
    while (tty_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run covered %0d input items, %0d of them without a result: %0d echoes,",
             items_in, discarded, kind_seen[cle_pkg::KIND_ECHO]);
    $display("%0d erases (largest %0d), %0d reads, %0d empty reads, %0d end-of-file marks.",
             kind_seen[cle_pkg::KIND_ERASE], max_erase, kind_seen[cle_pkg::KIND_READ],
             kind_seen[cle_pkg::KIND_EMPTY], kind_seen[cle_pkg::KIND_EOF]);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches in %0d result items", mismatches, results_seen);
      $display("== FAIL ==");
    end
    $finish;
  endtask

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_full_ring();
    test_random_lines();
    finish_run();
  end

endmodule

@@ sim.f @@
src/cle_pkg.sv
src/cle_ring.sv
src/cle_core.sv
src/console_line_editor_top.sv
src/cle_checker.sv
test/tb_console_line_editor_top.sv
